// ----- rtl/core/rgbe_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants of the RGB LED effect engine.
// ----------------------------------------------------------------------------
package rgbe_pkg;

  // effect modes
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_STEADY   = 3'd1;
  localparam logic [2:0] MODE_BLINK    = 3'd2;
  localparam logic [2:0] MODE_RAINBOW  = 3'd3;
  localparam logic [2:0] MODE_FADE_IN  = 3'd4;
  localparam logic [2:0] MODE_FADE_OUT = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] REG_BASE_COLOR  = 2'd1;
  localparam logic [1:0] REG_BLINK_COUNT = 2'd2;

  // color wheel segment bounds and step sizes
  localparam logic [7:0] WHEEL_SEG1  = 8'd85;
  localparam logic [7:0] WHEEL_SEG2  = 8'd170;
  localparam logic [8:0] FADE_STEP   = 9'd3;
  localparam logic [7:0] FULL_SCALE  = 8'd255;

  // effect state carried from item to item
  typedef struct packed {
    logic [23:0] shown_color;
    logic [8:0]  step_count;
    logic [8:0]  toggle_limit;
    logic        effect_active;
  } effect_state_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [2:0]  effect_mode;
    logic [23:0] base_color;
    logic [7:0]  blink_count;
  } effect_cfg_t;

endpackage

// ----- rtl/core/rgbe_step.sv -----
// ----------------------------------------------------------------------------
// rgbe_step
// Next-state logic for one input item: start, blink, wheel and fade steps.
// ----------------------------------------------------------------------------
module rgbe_step
  import rgbe_pkg::*;
(
  input  effect_cfg_t   cfg,
  input  effect_state_t cur,
  input  logic          start_req,
  input  logic          advance,
  output effect_state_t nxt
);

  logic [7:0]  pos;
  logic [7:0]  seg;
  logic [9:0]  seg_x3;
  logic [7:0]  ramp;
  logic [23:0] wheel_color;
  logic [7:0]  fade_eff;
  logic [7:0]  factor;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic [23:0] fade_color;

  // color wheel position, walked backwards
  always_comb begin
    pos = ~cur.step_count[7:0];
    if (pos < WHEEL_SEG1) begin
      seg = pos;
    end else if (pos < WHEEL_SEG2) begin
      seg = pos - WHEEL_SEG1;
    end else begin
      seg = pos - WHEEL_SEG2;
    end
    seg_x3 = {2'b00, seg} + {1'b0, seg, 1'b0};
    ramp   = seg_x3[7:0];
    if (pos < WHEEL_SEG1) begin
      wheel_color = {FULL_SCALE - ramp, 8'd0, ramp};
    end else if (pos < WHEEL_SEG2) begin
      wheel_color = {8'd0, ramp, FULL_SCALE - ramp};
    end else begin
      wheel_color = {ramp, FULL_SCALE - ramp, 8'd0};
    end
  end

  // fade scaling, step saturates at full scale
  always_comb begin
    fade_eff   = cur.step_count[8] ? FULL_SCALE : cur.step_count[7:0];
    factor     = (cfg.effect_mode == MODE_FADE_IN) ? fade_eff : ~fade_eff;
    prod_r     = {8'd0, cfg.base_color[23:16]} * {8'd0, factor};
    prod_g     = {8'd0, cfg.base_color[15:8]} * {8'd0, factor};
    prod_b     = {8'd0, cfg.base_color[7:0]} * {8'd0, factor};
    fade_color = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};
  end

  // state update
  always_comb begin
    nxt = cur;
    if (start_req) begin
      case (cfg.effect_mode)
        MODE_STEADY: begin
          nxt.shown_color   = cfg.base_color;
          nxt.effect_active = 1'b0;
        end
        MODE_BLINK: begin
          nxt.toggle_limit  = {cfg.blink_count, 1'b0};
          nxt.step_count    = '0;
          nxt.effect_active = 1'b1;
        end
        MODE_RAINBOW, MODE_FADE_IN, MODE_FADE_OUT: begin
          nxt.step_count    = '0;
          nxt.effect_active = 1'b1;
        end
        default: begin
          nxt.shown_color   = '0;
          nxt.effect_active = 1'b0;
        end
      endcase
    end else if (advance && cur.effect_active) begin
      case (cfg.effect_mode)
        MODE_BLINK: begin
          if (cur.toggle_limit != '0 && cur.step_count >= cur.toggle_limit) begin
            nxt.shown_color   = '0;
            nxt.effect_active = 1'b0;
          end else begin
            nxt.shown_color = (cur.shown_color == '0) ? cfg.base_color : '0;
            if (cur.toggle_limit != '0) begin
              nxt.step_count = cur.step_count + 9'd1;
            end
          end
        end
        MODE_RAINBOW: begin
          if (cur.step_count[8]) begin
            nxt.step_count = '0;
          end else begin
            nxt.shown_color = wheel_color;
            nxt.step_count  = cur.step_count + 9'd1;
          end
        end
        MODE_FADE_IN, MODE_FADE_OUT: begin
          nxt.shown_color = fade_color;
          if (cur.step_count < {1'b0, FULL_SCALE}) begin
            nxt.step_count = cur.step_count + FADE_STEP;
          end else begin
            nxt.step_count    = '0;
            nxt.effect_active = 1'b0;
          end
        end
        default: begin
          nxt.effect_active = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/rgb_led_effect_engine_core.sv -----
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_core
// Tick-driven RGB effect engine: off, steady, blink, rainbow, fade in/out.
// ----------------------------------------------------------------------------
// Usage:
//   in_* stream carries one item per transfer: start_req restarts the mode in
//   effect_mode, advance runs one effect step. Each item yields exactly one
//   result on the out_* stream: the shown color and the running flag.
//   cfg_* is a plain write port (cfg_we, cfg_addr, cfg_wdata) for effect_mode,
//   base_color and blink_count; write only while no item is in flight.
// Timing:
//   an accepted item is held in the input register, then the step logic
//   updates the effect state and loads the output register, which offers
//   the result on out_*. One item per cycle is sustained while out_tready
//   stays high; the state update is a loop through the step logic and the
//   state register alone.
// Reset and stalls:
//   rst_n (synchronous, active low) clears cfg_r, the valid flags and state_r
//   (black, idle). While out_tready is low the result is held, the input
//   register holds one more item, and in_tready drops once both are full.
// ----------------------------------------------------------------------------
module rgb_led_effect_engine_core
  import rgbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_req, [1] advance, [7:2] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue,
                                  // [24] running, [31:25] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  effect_cfg_t   cfg_r;
  effect_state_t state_r;
  effect_state_t state_nxt;
  logic          item_valid_r;
  logic          start_req_r;
  logic          advance_r;
  logic          out_valid_r;
  logic [23:0]   color_r;
  logic          running_r;
  logic          out_free;
  logic          fire;

  // handshake: step fires when an item is held and the output can take it
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = item_valid_r && out_free;
  assign in_tready = !item_valid_r || out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EFFECT_MODE: cfg_r.effect_mode <= cfg_wdata[2:0];
        REG_BASE_COLOR:  cfg_r.base_color  <= cfg_wdata;
        REG_BLINK_COUNT: cfg_r.blink_count <= cfg_wdata[7:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      start_req_r <= in_tdata[0];
      advance_r   <= in_tdata[1];
    end
  end

  // effect step logic
  rgbe_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .start_req (start_req_r),
    .advance   (advance_r),
    .nxt       (state_nxt)
  );

  // effect state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      color_r   <= state_nxt.shown_color;
      running_r <= state_nxt.effect_active;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, running_r, color_r[7:0], color_r[15:8], color_r[23:16]};

endmodule
